// ----- sv/mla_pkg.sv -----
// Shared types and constants of the motion and light alarm sequencer.
package mla_pkg;

   localparam int AXIS_COUNT     = 6;
   localparam int COUNT_WIDTH    = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_IDLE    = 2'd0;
   localparam mode_type MODE_INTERIM = 2'd1;
   localparam mode_type MODE_BUZZ    = 2'd2;
   localparam mode_type MODE_WAIT    = 2'd3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type REG_MOTION_THRESHOLD = 2'd0;
   localparam csr_index_type REG_LIGHT_THRESHOLD  = 2'd1;
   localparam csr_index_type REG_BUZZ_LENGTH      = 2'd2;
   localparam csr_index_type REG_WAIT_LENGTH      = 2'd3;

   localparam int RESET_MOTION_THRESHOLD = 5000;
   localparam int RESET_LIGHT_THRESHOLD  = 30000;
   localparam int RESET_BUZZ_LENGTH      = 8;
   localparam int RESET_WAIT_LENGTH      = 16;

endpackage

// ----- sv/motion_light_alarm_sequencer.sv -----
// Top level of the motion and light alarm sequencer.
// Takes one word per cycle while results are taken and returns exactly one result word per
// input word. The motion magnitude is formed from the request ports and captured with the
// word in the input register at the accepting edge. From there the mode sequencer
// (calibration, delta compares, buzz and wait counters) loads the result register and updates
// the sequencer state once the result register is free or its word is taken.
// The sequencer update sets the rate of one word per cycle. While a result
// waits, one more word can enter the input register; after that req_ready stays low until
// the result is taken.
module motion_light_alarm_sequencer #(
   parameter int AXIS_WIDTH  = 16,
   parameter int LIGHT_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [AXIS_WIDTH-1:0]         req_gyro_x,
   input  logic signed [AXIS_WIDTH-1:0]         req_gyro_y,
   input  logic signed [AXIS_WIDTH-1:0]         req_gyro_z,
   input  logic signed [AXIS_WIDTH-1:0]         req_accel_x,
   input  logic signed [AXIS_WIDTH-1:0]         req_accel_y,
   input  logic signed [AXIS_WIDTH-1:0]         req_accel_z,
   input  logic                                 req_motion_valid,
   input  logic [LIGHT_WIDTH-1:0]               req_light_level,
   input  logic                                 req_light_valid,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mla_pkg::mode_type                    rsp_mode,
   output logic                                 rsp_buzzer_on,
   output logic [AXIS_WIDTH+1:0]                rsp_motion_change,
   output logic [LIGHT_WIDTH-1:0]               rsp_light_change,
   output logic                                 rsp_cycle_flagged,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mla_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mla_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import mla_pkg::*;

   localparam int MOTION_WIDTH = AXIS_WIDTH + 2;

   // Configuration registers.
   logic [MOTION_WIDTH-1:0] motion_threshold_ff;
   logic [LIGHT_WIDTH-1:0]  light_threshold_ff;
   logic [COUNT_WIDTH-1:0]  buzz_length_ff;
   logic [COUNT_WIDTH-1:0]  wait_length_ff;

   // Input register.
   logic                         s1_valid_ff, s1_valid_in;
   logic [MOTION_WIDTH-1:0]      s1_magnitude_ff;
   logic                         s1_motion_valid_ff;
   logic [LIGHT_WIDTH-1:0]       s1_light_ff;
   logic                         s1_light_valid_ff;

   // Sequencer state.
   mode_type                     mode_ff, mode_in;
   logic [MOTION_WIDTH-1:0]      motion_base_ff, motion_base_in;
   logic [LIGHT_WIDTH-1:0]       light_base_ff, light_base_in;
   logic                         motion_ready_ff, motion_ready_in;
   logic                         light_ready_ff, light_ready_in;
   logic [COUNT_WIDTH-1:0]       buzz_count_ff, buzz_count_in;
   logic [COUNT_WIDTH-1:0]       wait_count_ff, wait_count_in;
   logic                         flagged_ff, flagged_in;
   logic                         buzzer_ff, buzzer_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   mode_type                     rsp_mode_ff;
   logic                         rsp_buzzer_ff;
   logic [MOTION_WIDTH-1:0]      rsp_motion_change_ff, motion_change_in;
   logic [LIGHT_WIDTH-1:0]       rsp_light_change_ff, light_change_in;
   logic                         rsp_flagged_ff;

   logic [AXIS_COUNT-1:0][AXIS_WIDTH-1:0] axis_bus;
   logic [MOTION_WIDTH-1:0]      magnitude;
   logic                         req_accept;
   logic                         s2_load;
   logic [MOTION_WIDTH-1:0]      motion_sample, motion_gap;
   logic [LIGHT_WIDTH-1:0]       light_sample, light_gap;
   logic [COUNT_WIDTH-1:0]       buzz_step, wait_step;

   // ---------------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_threshold_ff <= MOTION_WIDTH'(RESET_MOTION_THRESHOLD);
         light_threshold_ff  <= LIGHT_WIDTH'(RESET_LIGHT_THRESHOLD);
         buzz_length_ff      <= COUNT_WIDTH'(RESET_BUZZ_LENGTH);
         wait_length_ff      <= COUNT_WIDTH'(RESET_WAIT_LENGTH);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MOTION_THRESHOLD: motion_threshold_ff <= MOTION_WIDTH'(csr_wdata);
            REG_LIGHT_THRESHOLD:  light_threshold_ff  <= LIGHT_WIDTH'(csr_wdata);
            REG_BUZZ_LENGTH:      buzz_length_ff      <= csr_wdata[COUNT_WIDTH-1:0];
            REG_WAIT_LENGTH:      wait_length_ff      <= csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------------
   assign s2_load    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s2_load;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Motion magnitude into the input register
   // ---------------------------------------------------------------------------
   assign axis_bus = {req_accel_z, req_accel_y, req_accel_x,
                      req_gyro_z, req_gyro_y, req_gyro_x};

   mla_magnitude #(
      .AXIS_WIDTH (AXIS_WIDTH)
   ) u_magnitude (
      .axis_in   (axis_bus),
      .magnitude (magnitude)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_magnitude_ff    <= magnitude;
         s1_motion_valid_ff <= req_motion_valid;
         s1_light_ff        <= req_light_level;
         s1_light_valid_ff  <= req_light_valid;
      end
   end

   // ---------------------------------------------------------------------------
   // Mode sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      // The stored baseline stands in for an invalid sample.
      motion_sample = s1_motion_valid_ff ? s1_magnitude_ff : motion_base_ff;
      light_sample  = s1_light_valid_ff ? s1_light_ff : light_base_ff;
      motion_gap    = (motion_base_ff > motion_sample) ? motion_base_ff - motion_sample
                                                       : motion_sample - motion_base_ff;
      light_gap     = (light_base_ff > light_sample) ? light_base_ff - light_sample
                                                     : light_sample - light_base_ff;
      buzz_step     = buzz_count_ff + 1'b1;
      wait_step     = wait_count_ff + 1'b1;

      mode_in          = mode_ff;
      motion_base_in   = motion_base_ff;
      light_base_in    = light_base_ff;
      motion_ready_in  = motion_ready_ff;
      light_ready_in   = light_ready_ff;
      buzz_count_in    = buzz_count_ff;
      wait_count_in    = wait_count_ff;
      flagged_in       = flagged_ff;
      buzzer_in        = buzzer_ff;
      motion_change_in = '0;
      light_change_in  = '0;

      case (mode_ff)
         MODE_IDLE: begin
            if (!motion_ready_ff) begin
               motion_ready_in = 1'b1;
            end else begin
               motion_change_in = motion_gap;
               if (motion_gap > motion_threshold_ff) begin
                  mode_in        = MODE_INTERIM;
                  light_ready_in = 1'b0;
               end
            end
            motion_base_in = motion_sample;
         end
         MODE_INTERIM: begin
            if (!light_ready_ff) begin
               light_ready_in = 1'b1;
            end else begin
               light_change_in = light_gap;
               if (light_gap > light_threshold_ff) begin
                  mode_in        = MODE_BUZZ;
                  light_ready_in = 1'b0;
               end
            end
            light_base_in = light_sample;
         end
         MODE_BUZZ: begin
            if (buzz_count_ff == '0) begin
               buzzer_in = 1'b1;
            end
            if (!light_ready_ff) begin
               light_ready_in = 1'b1;
            end else begin
               light_change_in = light_gap;
               if (light_gap > light_threshold_ff) begin
                  flagged_in = 1'b1;
               end
            end
            light_base_in = light_sample;
            buzz_count_in = buzz_step;
            // A length of zero ends the phase on its first word, as a length of one does.
            if (buzz_step >= buzz_length_ff) begin
               buzzer_in = 1'b0;
               if (flagged_in) begin
                  mode_in         = MODE_IDLE;
                  motion_ready_in = 1'b0;
                  light_ready_in  = 1'b0;
                  buzz_count_in   = '0;
                  wait_count_in   = '0;
                  flagged_in      = 1'b0;
               end else begin
                  mode_in       = MODE_WAIT;
                  wait_count_in = '0;
               end
            end
         end
         default: begin
            if (!light_ready_ff) begin
               light_ready_in = 1'b1;
            end else begin
               light_change_in = light_gap;
               if (light_gap > light_threshold_ff) begin
                  flagged_in = 1'b1;
               end
            end
            light_base_in = light_sample;
            wait_count_in = wait_step;
            if (wait_step >= wait_length_ff) begin
               mode_in       = MODE_BUZZ;
               buzz_count_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         motion_base_ff  <= '0;
         light_base_ff   <= '0;
         motion_ready_ff <= 1'b0;
         light_ready_ff  <= 1'b0;
         buzz_count_ff   <= '0;
         wait_count_ff   <= '0;
         flagged_ff      <= 1'b0;
         buzzer_ff       <= 1'b0;
      end else if (s2_load) begin
         mode_ff         <= mode_in;
         motion_base_ff  <= motion_base_in;
         light_base_ff   <= light_base_in;
         motion_ready_ff <= motion_ready_in;
         light_ready_ff  <= light_ready_in;
         buzz_count_ff   <= buzz_count_in;
         wait_count_ff   <= wait_count_in;
         flagged_ff      <= flagged_in;
         buzzer_ff       <= buzzer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_mode_ff          <= mode_in;
         rsp_buzzer_ff        <= buzzer_in;
         rsp_motion_change_ff <= motion_change_in;
         rsp_light_change_ff  <= light_change_in;
         rsp_flagged_ff       <= flagged_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = rsp_mode_ff;
   assign rsp_buzzer_on     = rsp_buzzer_ff;
   assign rsp_motion_change = rsp_motion_change_ff;
   assign rsp_light_change  = rsp_light_change_ff;
   assign rsp_cycle_flagged = rsp_flagged_ff;

`ifndef SYNTHESIS
   // The buzzer only sounds while the sequencer sits in a buzz phase.
   assert property (@(posedge clock) disable iff (reset)
      buzzer_ff |-> (mode_ff == MODE_BUZZ))
      else $error("buzzer on outside buzz mode");

   // A flagged cycle is always cleared on the way back to idle.
   assert property (@(posedge clock) disable iff (reset)
      ((mode_ff == MODE_IDLE) || (mode_ff == MODE_INTERIM)) |-> !flagged_ff)
      else $error("cycle flag set outside the alarm cycle");

   // An accepted word always lands in the input register.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted word lost");

   // A result the sink has not taken is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !s2_load)
      else $error("stalled result overwritten");
`endif

endmodule

// ----- sv/mla_magnitude.sv -----
// Motion magnitude: sum of the absolute values of the six IMU axes.
module mla_magnitude #(
   parameter int AXIS_WIDTH = 16
) (
   input  logic [mla_pkg::AXIS_COUNT-1:0][AXIS_WIDTH-1:0] axis_in,
   output logic [AXIS_WIDTH+1:0]                          magnitude
);
   import mla_pkg::*;

   localparam int SUM_WIDTH = AXIS_WIDTH + 2;

   logic [AXIS_WIDTH-1:0] abs_val [AXIS_COUNT];

   // The most negative sample maps to 2**(AXIS_WIDTH-1), which still fits unsigned.
   always_comb begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
         abs_val[i] = axis_in[i][AXIS_WIDTH-1] ? (~axis_in[i] + 1'b1) : axis_in[i];
      end
   end

   always_comb begin
      magnitude = '0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         magnitude = magnitude + SUM_WIDTH'(abs_val[i]);
      end
   end

endmodule
